// ----- design/bms_pkg.sv -----
// Shared constants and types for the Boyer-Moore search unit.
// No dependencies.
`default_nettype none
package bms_pkg;
	localparam int PAT_MAX = 64;
	localparam int PAT_AW = 6;
	localparam int PLEN_W = 7;
	localparam int TXT_MAX = 4096;
	localparam int TXT_AW = 12;
	localparam int TLEN_W = 13;
	localparam int ALPH = 256;
	localparam int ALPH_AW = 8;
	localparam int TAB_W = 7;

	localparam logic [1:0] KIND_PAT = 2'd0;
	localparam logic [1:0] KIND_TXT = 2'd1;
	localparam logic [1:0] KIND_CLR = 2'd2;
	localparam logic [1:0] KIND_RSVD = 2'd3;

	typedef logic signed [9:0] idx_t;
	typedef logic signed [13:0] tidx_t;

	typedef struct packed {
		logic found;
		logic [11:0] position;
		logic pattern_overflow;
		logic text_overflow;
	} result_t;
endpackage
`default_nettype wire

// ----- design/bms_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bms_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(D)-1:0] waddr,
	input wire logic [W-1:0] wdata,
	input wire logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/bms_engine.sv -----
// Load, table build and search sequencer around the pattern, text and table RAMs.
// Depends on bms_pkg and bms_ram.
`default_nettype none
module bms_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire logic [1:0] kind,
	input wire logic [7:0] data_byte,
	input wire logic last,
	output logic idle,
	output logic res_valid,
	input wire logic res_take,
	output bms_pkg::result_t res
);
	typedef enum logic [4:0] {
		IDLE, BC_INIT, DI_RD, DI_WR,
		L1_TOP, L1_PJ, L1_CHK, L1_CMP,
		L2_TOP, L2_PJ, L2_CHK, L2_CMP,
		L3_TOP, L3_K, L3_KW, L3_F,
		S_START, S_TOP, S_RD, S_CMP, S_SH, DONE
	} st_t;

	st_t st_q;
	logic [bms_pkg::PLEN_W-1:0] plen_q;
	logic [bms_pkg::TLEN_W-1:0] tlen_q;
	logic pov_q, tov_q, closed_q, srch_q, found_q;
	logic [11:0] pos_q;
	logic [7:0] pj_q;
	bms_pkg::idx_t j_q, k_q, t_q, t1_q, q_q, q1_q;
	bms_pkg::tidx_t sk_q;

	logic p_we, t_we, bc_we, d_we, f_we;
	logic [bms_pkg::PAT_AW-1:0] p_wa, p_ra, d_wa, d_ra, f_wa, f_ra;
	logic [7:0] p_wd, p_rd, t_rd;
	logic [bms_pkg::TXT_AW-1:0] t_wa, t_ra;
	logic [bms_pkg::ALPH_AW-1:0] bc_wa, bc_ra;
	logic [bms_pkg::TAB_W-1:0] bc_wd, bc_rd, d_wd, d_rd, f_wd, f_rd;

	bms_pkg::idx_t mi, dr_i, fr_i, br_i, v1, v2, step;
	logic [bms_pkg::PLEN_W-1:0] eff_len;

	assign mi = bms_pkg::idx_t'({3'b0, plen_q});
	assign dr_i = bms_pkg::idx_t'({3'b0, d_rd});
	assign fr_i = bms_pkg::idx_t'({3'b0, f_rd});
	assign br_i = bms_pkg::idx_t'({3'b0, bc_rd});
	assign eff_len = closed_q ? '0 : plen_q;
	assign v1 = mi - j_q;
	assign v2 = mi + q_q - k_q;
	assign step = t_q - fr_i;
	assign idle = (st_q == IDLE);
	assign res_valid = (st_q == DONE);
	assign res = '{found: found_q, position: pos_q, pattern_overflow: pov_q,
		text_overflow: tov_q};

	always_comb begin
		p_we = 1'b0; p_wa = eff_len[bms_pkg::PAT_AW-1:0]; p_wd = data_byte;
		p_ra = '0;
		t_we = 1'b0; t_wa = tlen_q[bms_pkg::TXT_AW-1:0]; t_ra = sk_q[bms_pkg::TXT_AW-1:0];
		bc_we = 1'b0; bc_wa = k_q[bms_pkg::ALPH_AW-1:0]; bc_wd = plen_q; bc_ra = t_rd;
		d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
		f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
		case (st_q)
			IDLE: begin
				p_we = take && kind == bms_pkg::KIND_PAT
					&& eff_len < bms_pkg::PLEN_W'(bms_pkg::PAT_MAX);
				t_we = take && kind == bms_pkg::KIND_TXT
					&& tlen_q < bms_pkg::TLEN_W'(bms_pkg::TXT_MAX);
			end
			BC_INIT: bc_we = 1'b1;
			DI_RD: p_ra = 6'(k_q - 1);
			DI_WR: begin
				d_we = 1'b1; d_wa = 6'(k_q - 1); d_wd = 7'(2 * mi - k_q);
				bc_we = 1'b1; bc_wa = p_rd; bc_wd = 7'(mi - k_q);
			end
			L1_TOP, L2_TOP: begin
				f_wa = 6'(j_q - 1); p_ra = 6'(j_q - 1);
				f_wd = (st_q == L1_TOP) ? 7'(t_q) : 7'(t1_q);
				f_we = (st_q == L1_TOP) ? (j_q > 0) : (j_q <= t_q && j_q <= mi);
			end
			L1_CHK: begin
				p_ra = 6'(t_q - 1); d_ra = 6'(t_q - 1); f_ra = 6'(t_q - 1);
			end
			L1_CMP: begin
				d_we = (pj_q != p_rd); d_wa = 6'(t_q - 1);
				d_wd = (dr_i < v1) ? d_rd : 7'(v1);
			end
			L2_CHK: begin
				p_ra = 6'(t1_q - 1); f_ra = 6'(t1_q - 1);
			end
			L3_K: begin
				d_ra = 6'(k_q - 1); f_ra = 6'(t_q - 1);
			end
			L3_KW: begin
				d_we = 1'b1; d_wa = 6'(k_q - 1);
				d_wd = (dr_i < v2) ? d_rd : 7'(v2);
			end
			S_RD: p_ra = j_q[bms_pkg::PAT_AW-1:0];
			S_CMP: d_ra = j_q[bms_pkg::PAT_AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			plen_q <= '0; tlen_q <= '0;
			pov_q <= 1'b0; tov_q <= 1'b0; closed_q <= 1'b1; srch_q <= 1'b0;
		end else begin
			case (st_q)
				IDLE: begin
					if (take) begin
						case (kind)
							bms_pkg::KIND_PAT: begin
								closed_q <= 1'b0;
								if (eff_len < bms_pkg::PLEN_W'(bms_pkg::PAT_MAX)) begin
									plen_q <= eff_len + 1'b1;
									pov_q <= closed_q ? 1'b0 : pov_q;
								end else begin
									plen_q <= eff_len;
									pov_q <= 1'b1;
								end
								if (last) begin
									srch_q <= 1'b0; k_q <= '0; st_q <= BC_INIT;
								end
							end
							bms_pkg::KIND_CLR: begin
								plen_q <= '0; pov_q <= 1'b0; closed_q <= 1'b1;
							end
							bms_pkg::KIND_TXT: begin
								if (tlen_q < bms_pkg::TLEN_W'(bms_pkg::TXT_MAX))
									tlen_q <= tlen_q + 1'b1;
								else
									tov_q <= 1'b1;
								if (last) begin
									srch_q <= 1'b1; k_q <= '0;
									st_q <= closed_q ? S_START : BC_INIT;
								end
							end
							default: ;
						endcase
					end
				end
				BC_INIT: begin
					if (k_q == bms_pkg::idx_t'(bms_pkg::ALPH - 1)) begin
						k_q <= 10'sd1; st_q <= DI_RD;
					end else k_q <= k_q + 10'sd1;
				end
				DI_RD: begin
					if (k_q <= mi) st_q <= DI_WR;
					else if (mi == 0) begin
						closed_q <= 1'b1; st_q <= srch_q ? S_START : IDLE;
					end else begin
						t_q <= mi + 10'sd1; j_q <= mi; st_q <= L1_TOP;
					end
				end
				DI_WR: begin
					k_q <= k_q + 10'sd1; st_q <= DI_RD;
				end
				L1_TOP: begin
					if (j_q > 0) st_q <= L1_PJ;
					else begin
						q_q <= t_q; t_q <= mi + 10'sd1 - t_q; q1_q <= 10'sd1;
						t1_q <= '0; j_q <= 10'sd1; st_q <= L2_TOP;
					end
				end
				L1_PJ: begin
					pj_q <= p_rd; st_q <= L1_CHK;
				end
				L1_CHK: begin
					if (t_q <= mi && t_q >= 1) st_q <= L1_CMP;
					else begin
						j_q <= j_q - 10'sd1; t_q <= t_q - 10'sd1; st_q <= L1_TOP;
					end
				end
				L1_CMP: begin
					if (pj_q != p_rd) begin
						t_q <= fr_i; st_q <= L1_CHK;
					end else begin
						j_q <= j_q - 10'sd1; t_q <= t_q - 10'sd1; st_q <= L1_TOP;
					end
				end
				L2_TOP: st_q <= (j_q <= t_q && j_q <= mi) ? L2_PJ : L3_TOP;
				L2_PJ: begin
					pj_q <= p_rd; st_q <= L2_CHK;
				end
				L2_CHK: begin
					if (t1_q >= 1) st_q <= L2_CMP;
					else begin
						j_q <= j_q + 10'sd1; t1_q <= t1_q + 10'sd1; st_q <= L2_TOP;
					end
				end
				L2_CMP: begin
					if (pj_q != p_rd) begin
						t1_q <= fr_i; st_q <= L2_CHK;
					end else begin
						j_q <= j_q + 10'sd1; t1_q <= t1_q + 10'sd1; st_q <= L2_TOP;
					end
				end
				L3_TOP: begin
					if (q_q < mi) begin
						k_q <= q1_q; st_q <= L3_K;
					end else begin
						closed_q <= 1'b1; st_q <= srch_q ? S_START : IDLE;
					end
				end
				L3_K: begin
					if (k_q <= q_q) begin
						if (k_q >= 1 && k_q <= mi) st_q <= L3_KW;
						else k_q <= k_q + 10'sd1;
					end else if (t_q < 1 || t_q > mi) begin
						closed_q <= 1'b1; st_q <= srch_q ? S_START : IDLE;
					end else st_q <= L3_F;
				end
				L3_KW: begin
					k_q <= k_q + 10'sd1; st_q <= L3_K;
				end
				L3_F: begin
					if (step <= 0) begin
						closed_q <= 1'b1; st_q <= srch_q ? S_START : IDLE;
					end else begin
						q1_q <= q_q + 10'sd1; q_q <= q_q + step; t_q <= fr_i;
						st_q <= L3_TOP;
					end
				end
				S_START: begin
					if (mi == 0) begin
						found_q <= 1'b1; pos_q <= '0; st_q <= DONE;
					end else begin
						sk_q <= bms_pkg::tidx_t'(mi - 1); st_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (sk_q < bms_pkg::tidx_t'({1'b0, tlen_q})) begin
						j_q <= mi - 10'sd1; st_q <= S_RD;
					end else begin
						found_q <= 1'b0; pos_q <= '0; st_q <= DONE;
					end
				end
				S_RD: st_q <= S_CMP;
				S_CMP: begin
					if (t_rd == p_rd) begin
						if (j_q == 0) begin
							found_q <= 1'b1; pos_q <= sk_q[11:0]; st_q <= DONE;
						end else begin
							j_q <= j_q - 10'sd1; sk_q <= sk_q - 14'sd1; st_q <= S_RD;
						end
					end else st_q <= S_SH;
				end
				S_SH: begin
					sk_q <= sk_q + bms_pkg::tidx_t'((br_i > dr_i) ? br_i : dr_i);
					st_q <= S_TOP;
				end
				DONE: begin
					if (res_take) begin
						tlen_q <= '0; tov_q <= 1'b0; srch_q <= 1'b0; st_q <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	bms_ram #(.W(8), .D(bms_pkg::PAT_MAX)) u_pat (.clk, .we(p_we), .waddr(p_wa),
		.wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
	bms_ram #(.W(8), .D(bms_pkg::TXT_MAX)) u_txt (.clk, .we(t_we), .waddr(t_wa),
		.wdata(data_byte), .raddr(t_ra), .rdata(t_rd));
	bms_ram #(.W(bms_pkg::TAB_W), .D(bms_pkg::ALPH)) u_bc (.clk, .we(bc_we),
		.waddr(bc_wa), .wdata(bc_wd), .raddr(bc_ra), .rdata(bc_rd));
	bms_ram #(.W(bms_pkg::TAB_W), .D(bms_pkg::PAT_MAX)) u_gs (.clk, .we(d_we),
		.waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
	bms_ram #(.W(bms_pkg::TAB_W), .D(bms_pkg::PAT_MAX)) u_fail (.clk, .we(f_we),
		.waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= bms_pkg::PLEN_W'(bms_pkg::PAT_MAX)) else $error("pattern length");
	a_tlen: assert property (@(posedge clk) disable iff (!arst_n)
		tlen_q <= bms_pkg::TLEN_W'(bms_pkg::TXT_MAX)) else $error("text length");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> tlen_q == 0 && !tov_q && idle)
		else $error("text state not cleared");
	a_srch: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_START) |-> closed_q) else $error("search on open pattern");
endmodule
`default_nettype wire

// ----- design/boyer_moore_search_unit.sv -----
// Top level of the Boyer-Moore search unit: input handshake and result register.
// Depends on bms_pkg and bms_engine.
//
//  channel | signals                                   | dir
//  in      | in_valid in_ready kind data_byte last     | in
//  out     | out_valid out_ready found position        | out
//          | pattern_overflow text_overflow            |
//
// A pattern, text or clear byte transfers when in_valid and in_ready are both high.
// Last pattern byte: bad-character table init, fill of the good-suffix and bad-character tables,
// then the failure and good-suffix loops, all on the single read port of each RAM.
// Last text byte: byte compares and shifts through the text RAM.
// Reset empties and closes the pattern; in_ready stays low while tables build or search runs.
// A result held in the output register does not stop new bytes loading; a second result
// holds in_ready low until the first transfers.
`default_nettype none
module boyer_moore_search_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] data_byte,
	input wire logic last,
	output logic out_valid,
	input wire logic out_ready,
	output logic found,
	output logic [11:0] position,
	output logic pattern_overflow,
	output logic text_overflow
);
	logic idle, res_valid, res_take;
	bms_pkg::result_t res, out_q;

	assign in_ready = idle;
	assign res_take = res_valid && (!out_valid || out_ready);

	bms_engine u_eng (.clk, .arst_n, .take(in_valid && idle), .kind, .data_byte, .last,
		.idle, .res_valid, .res_take, .res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign found = out_q.found;
	assign position = out_q.position;
	assign pattern_overflow = out_q.pattern_overflow;
	assign text_overflow = out_q.text_overflow;
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for boyer_moore_search_unit: random pattern/text jobs under handshake idling.
// Scoreboard class predicts the Boyer-Moore search result; depends on bms_pkg.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	localparam int WATCHDOG_LIMIT = 200000;

	class search_scoreboard;
		logic [7:0] pat[bms_pkg::PAT_MAX];
		int pat_len;
		int bad_shift[bms_pkg::ALPH];
		int good_shift[bms_pkg::PAT_MAX];
		int fail_tab[bms_pkg::PAT_MAX];
		logic [7:0] txt[bms_pkg::TXT_MAX];
		int txt_len;
		bit pat_ovf;
		bit txt_ovf;
		bit pat_closed;
		bms_pkg::result_t expected_q[$];
		int errors;
		int results_seen;

		function new();
			pat_len = 0;
			txt_len = 0;
			pat_ovf = 0;
			txt_ovf = 0;
			pat_closed = 1;
			errors = 0;
			results_seen = 0;
		endfunction

		function int min2(int a, int b);
			return a < b ? a : b;
		endfunction

		function void build_shifts();
			int m, j, k, t, t1, q, q1, step;
			m = pat_len;
			for (k = 0; k < bms_pkg::ALPH; k++) bad_shift[k] = m;
			for (k = 1; k <= m; k++) begin
				good_shift[k-1] = 2 * m - k;
				bad_shift[pat[k-1]] = m - k;
			end
			if (m == 0) return;
			t = m + 1;
			for (j = m; j > 0; j--) begin
				fail_tab[j-1] = t;
				while (t <= m && t >= 1 && pat[j-1] != pat[t-1]) begin
					good_shift[t-1] = min2(good_shift[t-1], m - j);
					t = fail_tab[t-1];
				end
				t--;
			end
			q = t;
			t = m + 1 - q;
			q1 = 1;
			t1 = 0;
			for (j = 1; j <= t && j <= m; j++) begin
				fail_tab[j-1] = t1;
				while (t1 >= 1 && pat[j-1] != pat[t1-1]) t1 = fail_tab[t1-1];
				t1++;
			end
			while (q < m) begin
				for (k = q1; k <= q; k++)
					if (k >= 1 && k <= m) good_shift[k-1] = min2(good_shift[k-1], m + q - k);
				if (t < 1 || t > m) break;
				step = t - fail_tab[t-1];
				if (step <= 0) break;
				q1 = q + 1;
				q = q + step;
				t = fail_tab[t-1];
			end
		endfunction

		function bms_pkg::result_t search_text();
			bms_pkg::result_t r;
			int m, n, j, k, s1, s2;
			m = pat_len;
			n = txt_len;
			r = '0;
			r.pattern_overflow = pat_ovf;
			r.text_overflow = txt_ovf;
			if (m == 0) begin
				r.found = 1;
				return r;
			end
			k = m - 1;
			while (k < n) begin
				j = m - 1;
				while (j >= 0 && txt[k] == pat[j]) begin
					j--;
					k--;
				end
				if (j < 0) begin
					r.found = 1;
					r.position = 12'(k + 1);
					return r;
				end
				s1 = bad_shift[txt[k]];
				s2 = good_shift[j];
				k += s1 > s2 ? s1 : s2;
			end
			return r;
		endfunction

		function void note_input(logic [1:0] k, logic [7:0] b, logic l);
			if (k == bms_pkg::KIND_PAT) begin
				if (pat_closed) begin
					pat_len = 0;
					pat_ovf = 0;
					pat_closed = 0;
				end
				if (pat_len < bms_pkg::PAT_MAX) begin
					pat[pat_len] = b;
					pat_len++;
				end else pat_ovf = 1;
				if (l) begin
					build_shifts();
					pat_closed = 1;
				end
			end else if (k == bms_pkg::KIND_CLR) begin
				pat_len = 0;
				pat_ovf = 0;
				pat_closed = 1;
			end else if (k == bms_pkg::KIND_TXT) begin
				if (txt_len < bms_pkg::TXT_MAX) begin
					txt[txt_len] = b;
					txt_len++;
				end else txt_ovf = 1;
				if (l) begin
					if (!pat_closed) begin
						build_shifts();
						pat_closed = 1;
					end
					expected_q.push_back(search_text());
					txt_len = 0;
					txt_ovf = 0;
				end
			end
		endfunction

		function void check_result(bms_pkg::result_t got);
			bms_pkg::result_t e;
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result found=%0d position=%0d", $time,
					got.found, got.position);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.found !== e.found) begin
				$display("%0t: found expected %0d actual %0d", $time, e.found, got.found);
				errors++;
			end
			if (got.position !== e.position) begin
				$display("%0t: position expected %0d actual %0d", $time, e.position,
					got.position);
				errors++;
			end
			if (got.pattern_overflow !== e.pattern_overflow) begin
				$display("%0t: pattern_overflow expected %0d actual %0d", $time,
					e.pattern_overflow, got.pattern_overflow);
				errors++;
			end
			if (got.text_overflow !== e.text_overflow) begin
				$display("%0t: text_overflow expected %0d actual %0d", $time,
					e.text_overflow, got.text_overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] kind = bms_pkg::KIND_PAT;
	logic [7:0] data_byte = '0;
	logic last = 0;
	logic out_valid;
	logic out_ready = 0;
	logic found;
	logic [11:0] position;
	logic pattern_overflow;
	logic text_overflow;

	search_scoreboard sb = new();
	int src_idle = 0;
	int snk_stall = 0;
	int hold_req = 0;
	int hold_cnt = 0;
	int items_in = 0;
	int idle_cycles = 0;
	logic [7:0] last_pat[80];
	int last_pat_len = 0;

	boyer_moore_search_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .data_byte(data_byte), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .position(position),
		.pattern_overflow(pattern_overflow), .text_overflow(text_overflow)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result('{found, position, pattern_overflow, text_overflow});
		if (hold_req > 0 && hold_cnt == 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 0;
		end else out_ready <= ($urandom_range(99) >= snk_stall);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(logic [1:0] k, logic [7:0] b, logic l);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		data_byte <= b;
		last <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(k, b, l);
		items_in++;
	endtask

	function automatic logic [7:0] pick_byte(bit narrow);
		return narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom);
	endfunction

	task automatic run_job(int text_n);
		int r, m, n, i, off;
		bit narrow, open;
		r = $urandom_range(99);
		narrow = ($urandom_range(99) < 80);
		if (r < 8) begin
			send(bms_pkg::KIND_CLR, 8'($urandom), 1'($urandom));
			last_pat_len = 0;
		end else if (r < 12) send(bms_pkg::KIND_RSVD, 8'($urandom), 1'($urandom));
		else if (r < 60) begin
			m = ($urandom_range(99) < 3) ? $urandom_range(60, 70) : $urandom_range(1, 6);
			open = ($urandom_range(99) < 10);
			for (i = 0; i < m; i++) begin
				last_pat[i] = pick_byte(narrow);
				send(bms_pkg::KIND_PAT, last_pat[i], (i == m - 1) && !open);
			end
			last_pat_len = m;
		end
		n = text_n > 0 ? text_n : $urandom_range(1, 40);
		off = (last_pat_len > 0 && last_pat_len <= n && $urandom_range(1)) ?
			$urandom_range(0, n - last_pat_len) : -1;
		for (i = 0; i < n; i++) begin
			if (off >= 0 && i >= off && i < off + last_pat_len)
				send(bms_pkg::KIND_TXT, last_pat[i - off], i == n - 1);
			else send(bms_pkg::KIND_TXT, pick_byte(narrow), i == n - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int ph, target, i;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty pattern after reset, then byte extremes
		send(bms_pkg::KIND_TXT, 8'h00, 1);
		send(bms_pkg::KIND_PAT, 8'h00, 0);
		send(bms_pkg::KIND_PAT, 8'hff, 1);
		send(bms_pkg::KIND_TXT, 8'hff, 0);
		send(bms_pkg::KIND_TXT, 8'h00, 0);
		send(bms_pkg::KIND_TXT, 8'hff, 0);
		send(bms_pkg::KIND_TXT, 8'h00, 1);
		send(bms_pkg::KIND_RSVD, 8'h55, 1);
		send(bms_pkg::KIND_TXT, 8'h11, 1);
		send(bms_pkg::KIND_CLR, 8'hff, 1);
		send(bms_pkg::KIND_TXT, 8'h42, 1);
		send(bms_pkg::KIND_PAT, 8'h61, 0);
		send(bms_pkg::KIND_PAT, 8'h62, 0);
		send(bms_pkg::KIND_TXT, 8'h78, 0);
		send(bms_pkg::KIND_TXT, 8'h61, 0);
		send(bms_pkg::KIND_TXT, 8'h62, 1);
		send(bms_pkg::KIND_PAT, 8'h7a, 1);
		send(bms_pkg::KIND_TXT, 8'h61, 1);
		drain();

		// pattern and text beyond capacity
		for (i = 0; i < bms_pkg::PAT_MAX + 3; i++)
			send(bms_pkg::KIND_PAT, 8'h61, i == bms_pkg::PAT_MAX + 2);
		last_pat_len = 0;
		run_job(bms_pkg::TXT_MAX + 4);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle = 0; snk_stall = 0; hold_req = 3000; end
				1: begin src_idle = 86; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 86; end
				default: begin src_idle = 19; snk_stall = 19; end
			endcase
			target = items_in + 500;
			while (items_in < target) begin
				run_job(0);
				if ($urandom_range(99) < 3) drain();
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Ran %0d input transfers and checked %0d search results", items_in,
			sb.results_seen);
		$display("Covered empty, open and overlong patterns, overlong text and idling phases");
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- boyer_moore_search_unit.f -----
design/bms_pkg.sv
design/bms_ram.sv
design/bms_engine.sv
design/boyer_moore_search_unit.sv
dv/testbench.sv
